// ----- design/pmct_pkg.sv -----
// shared constants, register codes and helpers for the ps/2 mouse cursor tracker
// no dependencies; imported by the interfaces, the axis update and the top level
`default_nettype none

package pmct_pkg;

  // cursor coordinate width on the result channel
  localparam int unsigned COORD_BITS = 15;
  // default width of the internal position registers
  localparam int unsigned POSITION_BITS_DEFAULT = 15;
  // one received mouse byte
  localparam int unsigned BYTE_BITS = 8;
  // signed movement delta after sign handling and negation
  localparam int unsigned DELTA_BITS = 10;

  // apb port geometry
  localparam int unsigned APB_ADDR_BITS = 3;
  localparam int unsigned APB_DATA_BITS = 32;

  // register index codes (byte address bit 2)
  localparam logic REG_SCREEN_WIDTH  = 1'b0;
  localparam logic REG_SCREEN_HEIGHT = 1'b1;

  // register reset values
  localparam logic [COORD_BITS-1:0] SCREEN_WIDTH_RESET  = 15'd640;
  localparam logic [COORD_BITS-1:0] SCREEN_HEIGHT_RESET = 15'd480;

  // position of the next byte within a packet
  localparam logic [1:0] BYTE_HEADER = 2'd0;
  localparam logic [1:0] BYTE_XMOVE  = 2'd1;
  localparam logic [1:0] BYTE_YMOVE  = 2'd2;

  // header bit positions
  localparam int unsigned HDR_LEFT   = 0;
  localparam int unsigned HDR_RIGHT  = 1;
  localparam int unsigned HDR_MIDDLE = 2;
  localparam int unsigned HDR_XSIGN  = 4;
  localparam int unsigned HDR_YSIGN  = 5;

  // 9-bit two's-complement delta from a sign bit and a low byte, sign extended
  function automatic logic signed [DELTA_BITS-1:0] delta9(input logic sign_bit,
                                                          input logic [BYTE_BITS-1:0] low);
    logic signed [BYTE_BITS:0] d;
    d = signed'({sign_bit, low});
    return DELTA_BITS'(d);
  endfunction

endpackage

`default_nettype wire

// ----- design/pmct_if.sv -----
// valid/ready channel interfaces: mouse byte input and cursor result output
// depends on pmct_pkg for field widths
`default_nettype none

interface pmct_byte_if;
  logic                            valid;
  logic                            ready;
  logic [pmct_pkg::BYTE_BITS-1:0]  rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface pmct_cursor_if;
  logic                             valid;
  logic                             ready;
  logic [pmct_pkg::COORD_BITS-1:0]  cursor_x;
  logic [pmct_pkg::COORD_BITS-1:0]  cursor_y;
  logic                             button_left;
  logic                             button_middle;
  logic                             button_right;

  modport source (output valid, output cursor_x, output cursor_y, output button_left,
                  output button_middle, output button_right, input ready);
  modport sink   (input valid, input cursor_x, input cursor_y, input button_left,
                  input button_middle, input button_right, output ready);
endinterface

`default_nettype wire

// ----- design/pmct_axis.sv -----
// one coordinate update: add a signed delta and clamp to 0 .. min(size-1, max position)
// depends on pmct_pkg
`default_nettype none

module pmct_axis #(
  parameter int unsigned POSITION_BITS = pmct_pkg::POSITION_BITS_DEFAULT
) (
  input  logic [POSITION_BITS-1:0]                  pos,
  input  logic signed [pmct_pkg::DELTA_BITS-1:0]    delta,
  input  logic [pmct_pkg::COORD_BITS-1:0]           size,
  output logic [POSITION_BITS-1:0]                  pos_next
);
  import pmct_pkg::*;

  // signed work width: wide enough for either the position or the size, plus headroom
  localparam int unsigned SW =
    ((POSITION_BITS > COORD_BITS) ? POSITION_BITS : COORD_BITS) + 2;

  logic [COORD_BITS-1:0] size_eff;
  logic [COORD_BITS-1:0] limit_raw;
  logic signed [SW-1:0]  limit_size;
  logic signed [SW-1:0]  limit_cap;
  logic signed [SW-1:0]  limit;
  logic signed [SW-1:0]  sum;
  logic signed [SW-1:0]  clamped;

  // upper bound: zero size acts as one, and never beyond the position range
  always_comb begin
    size_eff   = (size == '0) ? COORD_BITS'(1) : size;
    limit_raw  = size_eff - COORD_BITS'(1);
    limit_size = {{(SW-COORD_BITS){1'b0}}, limit_raw};
    limit_cap  = {{(SW-POSITION_BITS){1'b0}}, {POSITION_BITS{1'b1}}};
    limit      = (limit_size < limit_cap) ? limit_size : limit_cap;
  end

  // move and clamp
  always_comb begin
    sum = signed'({{(SW-POSITION_BITS){1'b0}}, pos}) + SW'(delta);
    if (sum < 0) begin
      clamped = '0;
    end else if (sum > limit) begin
      clamped = limit;
    end else begin
      clamped = sum;
    end
    pos_next = clamped[POSITION_BITS-1:0];
  end

endmodule

`default_nettype wire

// ----- design/ps2_mouse_packet_cursor_tracker.sv -----
// Takes one ps/2 mouse byte per cycle while the result register is empty or being
// taken, and groups the bytes strictly in threes from reset (header, x move, y move).
// The first two bytes of a packet give no result; the third is decoded in the same
// cycle it is accepted and the new clamped cursor position and buttons are presented
// in the next cycle from the result register. A byte cannot be accepted while a
// result waits untaken. Screen width and height are written over the apb port (0x0
// width, 0x4 height); the user must write them only while the block is idle, and the
// block itself does not enforce it. No clearing pass after reset.
// depends on pmct_pkg, pmct_if and pmct_axis
`default_nettype none

module ps2_mouse_packet_cursor_tracker #(
  parameter int unsigned POSITION_BITS = pmct_pkg::POSITION_BITS_DEFAULT
) (
  input  logic                                   clk,
  input  logic                                   rst,
  pmct_byte_if.sink                              rx,
  pmct_cursor_if.source                          cursor,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [pmct_pkg::APB_ADDR_BITS-1:0]     paddr,
  input  logic [pmct_pkg::APB_DATA_BITS-1:0]     pwdata,
  output logic [pmct_pkg::APB_DATA_BITS-1:0]     prdata,
  output logic                                   pready
);
  import pmct_pkg::*;

  logic [COORD_BITS-1:0]         screen_width;
  logic [COORD_BITS-1:0]         screen_height;
  logic [1:0]                    byte_position;
  logic [BYTE_BITS-1:0]          header_byte;
  logic [BYTE_BITS-1:0]          x_move_byte;
  logic [POSITION_BITS-1:0]      pos_x;
  logic [POSITION_BITS-1:0]      pos_y;
  logic [POSITION_BITS-1:0]      pos_x_next;
  logic [POSITION_BITS-1:0]      pos_y_next;
  logic signed [DELTA_BITS-1:0]  delta_x;
  logic signed [DELTA_BITS-1:0]  delta_y;
  logic                          cfg_write;
  logic                          rx_transfer;
  logic                          out_valid;
  logic [COORD_BITS-1:0]         out_x;
  logic [COORD_BITS-1:0]         out_y;
  logic                          out_left;
  logic                          out_middle;
  logic                          out_right;

  // configuration registers
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= SCREEN_WIDTH_RESET;
      screen_height <= SCREEN_HEIGHT_RESET;
    end else if (cfg_write) begin
      case (paddr[2])
        REG_SCREEN_WIDTH:  screen_width  <= pwdata[COORD_BITS-1:0];
        REG_SCREEN_HEIGHT: screen_height <= pwdata[COORD_BITS-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (paddr[2])
      REG_SCREEN_WIDTH:  prdata = APB_DATA_BITS'(screen_width);
      REG_SCREEN_HEIGHT: prdata = APB_DATA_BITS'(screen_height);
      default:           prdata = '0;
    endcase
  end

  // input transfer whenever the result register is free or draining
  assign rx.ready    = !out_valid || cursor.ready;
  assign rx_transfer = rx.valid && rx.ready;

  // deltas: x as sent, y negated since screen y runs downward
  assign delta_x = delta9(header_byte[HDR_XSIGN], x_move_byte);
  assign delta_y = -delta9(header_byte[HDR_YSIGN], rx.rx_byte);

  pmct_axis #(.POSITION_BITS(POSITION_BITS)) u_axis_x (
    .pos      (pos_x),
    .delta    (delta_x),
    .size     (screen_width),
    .pos_next (pos_x_next)
  );

  pmct_axis #(.POSITION_BITS(POSITION_BITS)) u_axis_y (
    .pos      (pos_y),
    .delta    (delta_y),
    .size     (screen_height),
    .pos_next (pos_y_next)
  );

  // packet assembly and position update
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= BYTE_HEADER;
      header_byte   <= '0;
      x_move_byte   <= '0;
      pos_x         <= '0;
      pos_y         <= '0;
    end else if (rx_transfer) begin
      case (byte_position)
        BYTE_HEADER: begin
          header_byte   <= rx.rx_byte;
          byte_position <= BYTE_XMOVE;
        end
        BYTE_XMOVE: begin
          x_move_byte   <= rx.rx_byte;
          byte_position <= BYTE_YMOVE;
        end
        BYTE_YMOVE: begin
          pos_x         <= pos_x_next;
          pos_y         <= pos_y_next;
          byte_position <= BYTE_HEADER;
        end
        default: begin
          byte_position <= BYTE_HEADER;
        end
      endcase
    end
  end

  // result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rx_transfer && byte_position == BYTE_YMOVE) begin
      out_valid <= 1'b1;
    end else if (cursor.ready) begin
      out_valid <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (rx_transfer && byte_position == BYTE_YMOVE) begin
      out_x      <= COORD_BITS'(pos_x_next);
      out_y      <= COORD_BITS'(pos_y_next);
      out_left   <= header_byte[HDR_LEFT];
      out_middle <= header_byte[HDR_MIDDLE];
      out_right  <= header_byte[HDR_RIGHT];
    end
  end

  assign cursor.valid         = out_valid;
  assign cursor.cursor_x      = out_x;
  assign cursor.cursor_y      = out_y;
  assign cursor.button_left   = out_left;
  assign cursor.button_middle = out_middle;
  assign cursor.button_right  = out_right;

endmodule

`default_nettype wire

// ----- design/pmct_checker.sv -----
// port-level checks for the ps/2 mouse cursor tracker, bound to the top level
// depends on pmct_pkg; attaches to ps2_mouse_packet_cursor_tracker
`default_nettype none

module pmct_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              rx_valid,
  input logic                              rx_ready,
  input logic                              cur_valid,
  input logic                              cur_ready,
  input logic [pmct_pkg::COORD_BITS-1:0]   cur_x,
  input logic [pmct_pkg::COORD_BITS-1:0]   cur_y,
  input logic                              pready
);
  import pmct_pkg::*;

  // a result only appears in the cycle after a byte transfer
  a_result_after_transfer: assert property (@(posedge clk) disable iff (rst)
    $rose(cur_valid) |-> $past(rx_valid && rx_ready))
    else $error("result appeared without a preceding byte transfer");

  // clamp keeps both coordinates below the largest screen size
  a_coord_bound: assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> (cur_x != {COORD_BITS{1'b1}}) && (cur_y != {COORD_BITS{1'b1}}))
    else $error("cursor coordinate beyond the clamp bound");

  // a waiting result keeps the input side open only when it is being taken
  a_ready_follows_result: assert property (@(posedge clk) disable iff (rst)
    (cur_valid && !cur_ready) |-> !rx_ready)
    else $error("byte accepted while a stalled result holds the output");

  // stalled result holds
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (cur_valid && !cur_ready) |=> cur_valid && $stable(cur_x) && $stable(cur_y))
    else $error("stalled result changed");

  // apb port never inserts wait states
  a_pready_high: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready dropped");

endmodule

bind ps2_mouse_packet_cursor_tracker pmct_checker u_pmct_checker (
  .clk       (clk),
  .rst       (rst),
  .rx_valid  (rx.valid),
  .rx_ready  (rx.ready),
  .cur_valid (cursor.valid),
  .cur_ready (cursor.ready),
  .cur_x     (cursor.cursor_x),
  .cur_y     (cursor.cursor_y),
  .pready    (pready)
);

`default_nettype wire
